### sv/fwe_pkg.sv
package fwe_pkg;

  localparam int NumFlags   = 32;
  localparam int NumThreads = 32;
  localparam int FlagIdxW   = $clog2(NumFlags);
  localparam int ThreadIdxW = $clog2(NumThreads);
  localparam int CauseW     = 6;

  localparam logic [CauseW-1:0] CauseNone = CauseW'(32);

  typedef logic [NumFlags-1:0]   flag_set_t;
  typedef logic [NumThreads-1:0] thread_set_t;

  typedef enum logic [2:0] {
    KIND_CREATE  = 3'd0,
    KIND_RUN     = 3'd1,
    KIND_ALLOC   = 3'd2,
    KIND_RELEASE = 3'd3,
    KIND_WAIT    = 3'd4,
    KIND_SIGNAL  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NO_FLAG    = 2'd1,
    STATUS_EMPTY_MASK = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_CREATE,
    JOB_WAIT,
    JOB_ALLOC,
    JOB_SIGNAL
  } job_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_LATCH,
    SEQ_WALK,
    SEQ_DONE
  } seq_state_e;

  typedef enum logic [1:0] {
    ROW_CLEAR_THREAD,
    ROW_SET_THREAD,
    ROW_CLEAR_SET,
    ROW_ZERO
  } row_mode_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  thread_id;
    logic [4:0]  flag_id;
    logic [31:0] flag_mask;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  new_flag;
    logic [31:0] woken_threads;
    logic [31:0] runnable_set;
    logic [31:0] waiting_set;
    logic [5:0]  thread_cause;
  } out_item_t;

  typedef struct packed {
    row_mode_e               mode;
    logic [ThreadIdxW-1:0]   tid;
    thread_set_t             clr_set;
  } row_op_t;

  typedef struct packed {
    logic                  start;
    logic                  ack;
    job_e                  job;
    logic [ThreadIdxW-1:0] tid;
    logic [FlagIdxW-1:0]   fid;
    flag_set_t             mask;
    flag_set_t             free_flags;
  } seq_req_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [FlagIdxW-1:0] new_flag;
    thread_set_t         woken;
  } seq_rsp_t;

endpackage

### sv/fwe_ram.sv
module fwe_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fwe_row_unit.sv
module fwe_row_unit (
  input  fwe_pkg::row_op_t    op_i,
  input  fwe_pkg::thread_set_t row_i,
  output fwe_pkg::thread_set_t row_o
);

  fwe_pkg::thread_set_t bit_sel;

  assign bit_sel = fwe_pkg::thread_set_t'(1) << op_i.tid;

  always_comb begin
    unique case (op_i.mode)
      fwe_pkg::ROW_CLEAR_THREAD: row_o = row_i & ~bit_sel;
      fwe_pkg::ROW_SET_THREAD:   row_o = row_i | bit_sel;
      fwe_pkg::ROW_CLEAR_SET:    row_o = row_i & ~op_i.clr_set;
      fwe_pkg::ROW_ZERO:         row_o = '0;
      default:                   row_o = row_i;
    endcase
  end

endmodule

### sv/fwe_seq.sv
module fwe_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fwe_pkg::seq_req_t    req_i,
  output fwe_pkg::seq_rsp_t    rsp_o
);

  fwe_pkg::seq_state_e state_q, state_d;

  logic [fwe_pkg::FlagIdxW-1:0] cnt_q, cnt_d;
  logic                         issue_done_q, issue_done_d;
  logic                         wb_vld_q, wb_vld_d;
  logic [fwe_pkg::FlagIdxW-1:0] wb_idx_q, wb_idx_d;
  logic                         rd_vld_q;
  fwe_pkg::flag_set_t           row_vld_q, row_vld_d;
  logic                         found_q, found_d;
  logic [fwe_pkg::FlagIdxW-1:0] new_flag_q, new_flag_d;
  fwe_pkg::thread_set_t         woken_q, woken_d;

  logic [fwe_pkg::FlagIdxW-1:0] raddr;
  logic                         issue;
  logic                         we;
  fwe_pkg::thread_set_t         rdata;
  fwe_pkg::thread_set_t         row_eff;
  fwe_pkg::thread_set_t         row_new;
  fwe_pkg::row_op_t             row_op;

  fwe_ram #(
    .Width(fwe_pkg::NumThreads),
    .Depth(fwe_pkg::NumFlags)
  ) u_wait_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wb_idx_q),
    .wdata_i(row_new),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  fwe_row_unit u_row_unit (
    .op_i (row_op),
    .row_i(row_eff),
    .row_o(row_new)
  );

  assign row_eff = rd_vld_q ? rdata : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwe_pkg::SEQ_IDLE: begin
        if (req_i.start) begin
          priority if (req_i.job == fwe_pkg::JOB_NONE) begin
            state_d = fwe_pkg::SEQ_DONE;
          end else if (req_i.job == fwe_pkg::JOB_SIGNAL) begin
            state_d = fwe_pkg::SEQ_FETCH;
          end else begin
            state_d = fwe_pkg::SEQ_WALK;
          end
        end
      end
      fwe_pkg::SEQ_FETCH: state_d = fwe_pkg::SEQ_LATCH;
      fwe_pkg::SEQ_LATCH: state_d = fwe_pkg::SEQ_WALK;
      fwe_pkg::SEQ_WALK: begin
        if (issue_done_q && !wb_vld_q) begin
          state_d = fwe_pkg::SEQ_DONE;
        end
      end
      fwe_pkg::SEQ_DONE: begin
        if (req_i.ack) begin
          state_d = fwe_pkg::SEQ_IDLE;
        end
      end
      default: state_d = fwe_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    raddr        = (state_q == fwe_pkg::SEQ_FETCH) ? req_i.fid : cnt_q;
    issue        = (state_q == fwe_pkg::SEQ_WALK) && !issue_done_q;
    cnt_d        = cnt_q;
    issue_done_d = issue_done_q;
    wb_vld_d     = 1'b0;
    wb_idx_d     = wb_idx_q;
    found_d      = found_q;
    new_flag_d   = new_flag_q;
    woken_d      = woken_q;
    row_vld_d    = row_vld_q;
    we           = 1'b0;
    row_op.tid     = req_i.tid;
    row_op.clr_set = woken_q;
    row_op.mode    = fwe_pkg::ROW_ZERO;

    if ((state_q == fwe_pkg::SEQ_IDLE) && req_i.start) begin
      cnt_d        = '0;
      issue_done_d = 1'b0;
      found_d      = 1'b0;
      new_flag_d   = '0;
      woken_d      = '0;
    end

    if (state_q == fwe_pkg::SEQ_LATCH) begin
      woken_d = row_eff;
    end

    if (issue) begin
      wb_vld_d = 1'b1;
      wb_idx_d = cnt_q;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == fwe_pkg::FlagIdxW'(fwe_pkg::NumFlags - 1)) begin
        issue_done_d = 1'b1;
      end
    end

    if (wb_vld_q) begin
      unique case (req_i.job)
        fwe_pkg::JOB_CREATE: begin
          row_op.mode = fwe_pkg::ROW_CLEAR_THREAD;
          we          = 1'b1;
        end
        fwe_pkg::JOB_WAIT: begin
          row_op.mode = fwe_pkg::ROW_SET_THREAD;
          we          = req_i.mask[wb_idx_q];
        end
        fwe_pkg::JOB_SIGNAL: begin
          row_op.mode = fwe_pkg::ROW_CLEAR_SET;
          we          = 1'b1;
        end
        fwe_pkg::JOB_ALLOC: begin
          row_op.mode = fwe_pkg::ROW_ZERO;
          if (!found_q && req_i.free_flags[wb_idx_q]) begin
            we         = 1'b1;
            found_d    = 1'b1;
            new_flag_d = wb_idx_q;
          end
        end
        default: we = 1'b0;
      endcase
    end

    if (we) begin
      row_vld_d[wb_idx_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fwe_pkg::SEQ_IDLE;
      cnt_q        <= '0;
      issue_done_q <= 1'b0;
      wb_vld_q     <= 1'b0;
      wb_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      row_vld_q    <= '0;
      found_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      issue_done_q <= issue_done_d;
      wb_vld_q     <= wb_vld_d;
      wb_idx_q     <= wb_idx_d;
      rd_vld_q     <= row_vld_q[raddr];
      row_vld_q    <= row_vld_d;
      found_q      <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_flag_q <= new_flag_d;
    woken_q    <= woken_d;
  end

  assign rsp_o.done     = (state_q == fwe_pkg::SEQ_DONE);
  assign rsp_o.found    = found_q;
  assign rsp_o.new_flag = new_flag_q;
  assign rsp_o.woken    = woken_q;

endmodule

### sv/event_flag_wait_wake_engine_core.sv
// Channel   Direction  Signals                               Beat contents
// in        input      in_valid_i, in_ready_o, in_item_i     one command
// out       output     out_valid_o, out_ready_i, out_item_o  one result
//
// A create, allocate or wait command walks the wait matrix RAM, one row per cycle, before
// its result beat; a signal first fetches and latches its flag's row, then walks likewise.
// Run, release, unknown and empty-mask wait commands skip the walk.
// After reset the block is ready at once; the RAM rows read as zero until written.
// A new command can be taken as soon as a result is registered and may run while that
// result waits; a full output register holds the next command in its done state.
module event_flag_wait_wake_engine_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fwe_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fwe_pkg::out_item_t out_item_o
);

  fwe_pkg::in_item_t    cmd_q;
  logic                 busy_q;
  logic                 start_q;
  fwe_pkg::flag_set_t   alloc_q, alloc_d;
  fwe_pkg::thread_set_t created_q, created_d;
  fwe_pkg::thread_set_t runnable_q, runnable_d;
  fwe_pkg::thread_set_t waiting_q, waiting_d;
  logic [fwe_pkg::CauseW-1:0] cause_q [fwe_pkg::NumThreads];
  logic [fwe_pkg::CauseW-1:0] cause_d [fwe_pkg::NumThreads];
  fwe_pkg::out_item_t   out_q, out_d;
  logic                 out_valid_q;

  logic                          accept;
  logic                          ack;
  logic                          tok;
  logic                          fok;
  logic [fwe_pkg::ThreadIdxW-1:0] tidx;
  logic [fwe_pkg::FlagIdxW-1:0]   fidx;
  fwe_pkg::flag_set_t            mask_eff;
  fwe_pkg::job_e                 job;
  fwe_pkg::seq_req_t             req;
  fwe_pkg::seq_rsp_t             rsp;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign ack        = rsp.done && (!out_valid_q || out_ready_i);

  assign tok      = int'(cmd_q.thread_id) < fwe_pkg::NumThreads;
  assign fok      = int'(cmd_q.flag_id) < fwe_pkg::NumFlags;
  assign tidx     = fwe_pkg::ThreadIdxW'(cmd_q.thread_id);
  assign fidx     = fwe_pkg::FlagIdxW'(cmd_q.flag_id);
  assign mask_eff = fwe_pkg::flag_set_t'(cmd_q.flag_mask);

  always_comb begin
    job = fwe_pkg::JOB_NONE;
    unique case (cmd_q.kind)
      fwe_pkg::KIND_CREATE: if (tok) job = fwe_pkg::JOB_CREATE;
      fwe_pkg::KIND_ALLOC:  job = fwe_pkg::JOB_ALLOC;
      fwe_pkg::KIND_WAIT:   if (tok && (mask_eff != '0)) job = fwe_pkg::JOB_WAIT;
      fwe_pkg::KIND_SIGNAL: if (fok) job = fwe_pkg::JOB_SIGNAL;
      default:              job = fwe_pkg::JOB_NONE;
    endcase
  end

  always_comb begin
    req.start      = start_q;
    req.ack        = ack;
    req.job        = job;
    req.tid        = tidx;
    req.fid        = fidx;
    req.mask       = mask_eff;
    req.free_flags = ~alloc_q;
  end

  fwe_seq u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  always_comb begin
    alloc_d    = alloc_q;
    created_d  = created_q;
    runnable_d = runnable_q;
    waiting_d  = waiting_q;
    cause_d    = cause_q;
    out_d      = out_q;

    if (ack) begin
      out_d.status        = fwe_pkg::STATUS_OK;
      out_d.new_flag      = '0;
      out_d.woken_threads = '0;

      unique case (cmd_q.kind)
        fwe_pkg::KIND_CREATE: begin
          if (tok) begin
            cause_d[tidx]   = fwe_pkg::CauseNone;
            created_d[tidx] = 1'b1;
          end
        end
        fwe_pkg::KIND_RUN: begin
          if (tok) begin
            runnable_d[tidx] = 1'b1;
          end
        end
        fwe_pkg::KIND_ALLOC: begin
          if (rsp.found) begin
            alloc_d[rsp.new_flag] = 1'b1;
            out_d.new_flag        = 5'(rsp.new_flag);
          end else begin
            out_d.status = fwe_pkg::STATUS_NO_FLAG;
          end
        end
        fwe_pkg::KIND_RELEASE: begin
          if (fok) begin
            alloc_d[fidx] = 1'b0;
          end
        end
        fwe_pkg::KIND_WAIT: begin
          if (tok) begin
            if (mask_eff == '0) begin
              out_d.status = fwe_pkg::STATUS_EMPTY_MASK;
            end else begin
              runnable_d[tidx] = 1'b0;
              waiting_d[tidx]  = 1'b1;
            end
          end
        end
        fwe_pkg::KIND_SIGNAL: begin
          if (fok) begin
            for (int t = 0; t < fwe_pkg::NumThreads; t++) begin
              if (rsp.woken[t]) begin
                cause_d[t] = fwe_pkg::CauseW'(cmd_q.flag_id);
              end
            end
            waiting_d           = waiting_q & ~rsp.woken;
            runnable_d          = runnable_q | rsp.woken;
            out_d.woken_threads = 32'(rsp.woken);
          end
        end
        default: out_d.status = fwe_pkg::STATUS_OK;
      endcase

      out_d.runnable_set = 32'(runnable_d);
      out_d.waiting_set  = 32'(waiting_d);
      out_d.thread_cause = tok ? cause_d[tidx] : fwe_pkg::CauseNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      alloc_q     <= '0;
      created_q   <= '0;
      runnable_q  <= '0;
      waiting_q   <= '0;
      for (int t = 0; t < fwe_pkg::NumThreads; t++) begin
        cause_q[t] <= fwe_pkg::CauseNone;
      end
    end else begin
      start_q    <= accept;
      alloc_q    <= alloc_d;
      created_q  <= created_d;
      runnable_q <= runnable_d;
      waiting_q  <= waiting_d;
      cause_q    <= cause_d;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (ack) begin
        busy_q <= 1'b0;
      end
      if (ack) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      cmd_q <= in_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
